[rtl/core/running_median_filter_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the running median filter
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_FILTER_MACROS_SVH
`define RUNNING_MEDIAN_FILTER_MACROS_SVH

// Same-cycle implication.
`define RMF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rmf_pkg.sv]
// ----------------------------------------------------------------------------
// Running median filter package
// Sizes, register indexes and the link record shared by the sort cells.
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam int MAX_WINDOW   = 32;
    localparam int SAMPLE_WIDTH = 16;
    localparam int TAG_W        = $clog2(MAX_WINDOW);
    localparam int LEN_W        = 6;
    localparam int CFG_W        = 16;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic [TAG_W-1:0]               t_tag;
    typedef logic [LEN_W-1:0]               t_len;

    // Register indexes of the configuration port.
    typedef enum logic {
        REG_WINDOW_LENGTH = 1'b0,
        REG_FILL_VALUE    = 1'b1
    } t_reg_idx;

    localparam t_len RESET_LENGTH = t_len'(5);
    localparam t_len MAX_LENGTH   = t_len'(MAX_WINDOW);

    // What one sort cell shows its neighbors and the top level.
    typedef struct packed {
        t_sample next_value; // value after this cycle's update
        t_sample value;      // stored value at this rank
        t_tag    tag;        // window slot held at this rank
        logic    lt;         // above the replaced rank and below the new sample
        logic    gt;         // under the replaced rank and above the new sample
        logic    mark;       // the replaced rank is at or below this cell
        logic    hit;        // this cell holds the slot being replaced
    } t_cell_out;

endpackage

[rtl/core/running_median_filter.sv]
// ----------------------------------------------------------------------------
// Running median filter
// Sliding-window median of a signed sample stream over a row of sort cells.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  s_axis   in         tdata[15:0] = sample
//  m_axis   out        tdata[15:0] = median
//  cfg      in         idx 0 = window_length, idx 1 = fill_value
//
//  One word is taken per cycle while s_axis tready is high; its median is
//  registered in the output register, or in the skid register under a stall.
//  The cell row updates with the replaced-rank marker rippling through the
//  32 cells as the long path. A configuration write reloads every cell.
//  Reset gives a window of 5 zeros; a stalled output holds one more word in
//  a skid register before s_axis tready drops.
// ----------------------------------------------------------------------------
`include "running_median_filter_macros.svh"

module running_median_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [rmf_pkg::SAMPLE_WIDTH-1:0]  i_s_axis_tdata,  // [15:0] sample
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [rmf_pkg::SAMPLE_WIDTH-1:0]  o_m_axis_tdata,  // [15:0] median
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [rmf_pkg::CFG_W-1:0]         i_cfg_wdata
);

    localparam int MW = rmf_pkg::MAX_WINDOW;

    rmf_pkg::t_len      r_len;
    rmf_pkg::t_len      n_len;
    rmf_pkg::t_sample   r_fill;
    rmf_pkg::t_sample   n_fill;
    rmf_pkg::t_tag      r_oldest;
    rmf_pkg::t_len      w_cfg_len;
    rmf_pkg::t_len      w_oldest_len;
    logic               w_accept;
    logic               w_load;
    rmf_pkg::t_sample   w_sample;
    rmf_pkg::t_cell_out w_cell [MW];
    logic [MW-1:0]      w_hit;
    logic [rmf_pkg::TAG_W-1:0] w_med_idx;

    assign w_sample = rmf_pkg::t_sample'(i_s_axis_tdata);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load   = i_cfg_we;

    always_comb begin
        w_cfg_len = i_cfg_wdata[rmf_pkg::LEN_W-1:0];
        if (w_cfg_len == '0) begin
            w_cfg_len = rmf_pkg::t_len'(1);
        end else if (w_cfg_len > rmf_pkg::MAX_LENGTH) begin
            w_cfg_len = rmf_pkg::MAX_LENGTH;
        end
    end

    always_comb begin
        n_len  = r_len;
        n_fill = r_fill;
        if (i_cfg_we) begin
            unique case (rmf_pkg::t_reg_idx'(i_cfg_idx))
                rmf_pkg::REG_WINDOW_LENGTH: n_len  = w_cfg_len;
                rmf_pkg::REG_FILL_VALUE:    n_fill = rmf_pkg::t_sample'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    assign w_oldest_len = n_len - rmf_pkg::t_len'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= rmf_pkg::RESET_LENGTH;
            r_fill   <= '0;
            r_oldest <= rmf_pkg::t_tag'(rmf_pkg::RESET_LENGTH - rmf_pkg::t_len'(1));
        end else begin
            r_len  <= n_len;
            r_fill <= n_fill;
            if (w_load) begin
                r_oldest <= w_oldest_len[rmf_pkg::TAG_W-1:0];
            end else if (w_accept) begin
                if (r_oldest == '0) begin
                    r_oldest <= rmf_pkg::t_tag'(r_len - rmf_pkg::t_len'(1));
                end else begin
                    r_oldest <= r_oldest - rmf_pkg::t_tag'(1);
                end
            end
        end
    end

    for (genvar gi = 0; gi < MW; gi++) begin : g_cell
        localparam rmf_pkg::t_len IDX = rmf_pkg::t_len'(gi);
        rmf_pkg::t_cell_out w_lo;
        rmf_pkg::t_cell_out w_up;

        if (gi == 0) begin : g_lo_edge
            assign w_lo = '0;
        end else begin : g_lo_link
            assign w_lo = w_cell[gi-1];
        end
        if (gi == MW - 1) begin : g_up_edge
            assign w_up = '0;
        end else begin : g_up_link
            assign w_up = w_cell[gi+1];
        end

        rmf_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (IDX[rmf_pkg::TAG_W-1:0]),
            .i_active (IDX < r_len),
            .i_load   (w_load),
            .i_fill   (n_fill),
            .i_step   (w_accept),
            .i_sample (w_sample),
            .i_oldest (r_oldest),
            .i_lower  (w_lo),
            .i_upper  (w_up),
            .o_cell   (w_cell[gi])
        );

        assign w_hit[gi] = w_cell[gi].hit;
    end

    assign w_med_idx = r_len[rmf_pkg::LEN_W-1:1];

    rmf_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_cell[w_med_idx].next_value),
        .o_ready (o_s_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata),
        .i_ready (i_m_axis_tready)
    );

    `RMF_ASSERT_NOW(a_len_in_range, 1'b1, (r_len != '0) && (r_len <= rmf_pkg::MAX_LENGTH), "window length out of range")
    `RMF_ASSERT_NOW(a_oldest_in_window, 1'b1, rmf_pkg::t_len'(r_oldest) < r_len, "oldest slot outside window")
    `RMF_ASSERT_NOW(a_one_replaced_rank, 1'b1, $onehot(w_hit), "replaced slot not held by exactly one rank")

endmodule

[rtl/core/rmf_cell.sv]
// ----------------------------------------------------------------------------
// Running median sort cell
// Holds one rank of the sorted window and shifts with its neighbors.
// ----------------------------------------------------------------------------
`include "running_median_filter_macros.svh"

module rmf_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rmf_pkg::t_tag       i_idx,
    input  logic                i_active,
    input  logic                i_load,
    input  rmf_pkg::t_sample    i_fill,
    input  logic                i_step,
    input  rmf_pkg::t_sample    i_sample,
    input  rmf_pkg::t_tag       i_oldest,
    input  rmf_pkg::t_cell_out  i_lower,
    input  rmf_pkg::t_cell_out  i_upper,
    output rmf_pkg::t_cell_out  o_cell
);

    rmf_pkg::t_sample r_value;
    rmf_pkg::t_sample n_value;
    rmf_pkg::t_tag    r_tag;
    rmf_pkg::t_tag    n_tag;
    logic             w_hit;
    logic             w_lt;
    logic             w_gt;

    // The replaced entry leaves; entries between it and the new sample's
    // place shift one rank toward it, and ties keep their side.
    assign w_hit = i_active && (r_tag == i_oldest);
    assign w_lt  = i_active && i_lower.mark && (r_value < i_sample);
    assign w_gt  = i_active && !i_lower.mark && !w_hit && (r_value > i_sample);

    always_comb begin
        n_value = r_value;
        n_tag   = r_tag;
        if (i_load) begin
            n_value = i_fill;
            n_tag   = i_idx;
        end else if (i_step && i_active) begin
            if (i_upper.lt) begin
                n_value = i_upper.value;
                n_tag   = i_upper.tag;
            end else if (i_lower.gt) begin
                n_value = i_lower.value;
                n_tag   = i_lower.tag;
            end else if (w_hit || w_lt || w_gt) begin
                n_value = i_sample;
                n_tag   = i_oldest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_tag   <= i_idx;
        end else begin
            r_value <= n_value;
            r_tag   <= n_tag;
        end
    end

    assign o_cell.next_value = n_value;
    assign o_cell.value      = r_value;
    assign o_cell.tag        = r_tag;
    assign o_cell.lt         = w_lt;
    assign o_cell.gt         = w_gt;
    assign o_cell.mark       = i_lower.mark || w_hit;
    assign o_cell.hit        = w_hit;

    `RMF_ASSERT_NOW(a_cell_no_both_sides, i_active, !(w_lt && w_gt), "cell on both sides of the replaced rank")

endmodule

[rtl/core/rmf_out_buf.sv]
// ----------------------------------------------------------------------------
// Running median output buffer
// Output register with a skid word that takes one more word under a stall.
// ----------------------------------------------------------------------------
`include "running_median_filter_macros.svh"

module rmf_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rmf_pkg::t_sample i_data,
    output logic             o_ready,
    output logic             o_valid,
    output rmf_pkg::t_sample o_data,
    input  logic             i_ready
);

    logic             r_out_valid;
    rmf_pkg::t_sample r_out_data;
    logic             r_skid_valid;
    rmf_pkg::t_sample r_skid_data;
    logic             w_pop;

    assign w_pop   = r_out_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid) begin
            r_out_valid <= i_push;
            if (i_push) begin
                r_out_data <= i_data;
            end
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_out_data <= i_data;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= i_data;
        end
    end

    `RMF_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid word held without output word")
    `RMF_ASSERT_NEXT(a_stall_fills_skid, r_out_valid && !i_ready && i_push, r_skid_valid, "stalled word not caught in skid")

endmodule
